FILE: src/ntcpl_pkg.sv
// Shared constants and types for the NTC polynomial linearizer.
// Used by every module in src; depends on nothing.
package ntcpl_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned COEFF_W    = 32;
  localparam int unsigned X_W        = 24;
  localparam int unsigned RES_W      = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned DIGIT_W    = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned NUM_COEFF  = 7;
  localparam int unsigned K_W        = 3;
  localparam int unsigned OUT_SHIFT  = 30;

  localparam int unsigned TERM_W      = COEFF_W + X_W;
  localparam int unsigned SCALE_STEPS = SAMPLE_W / DIGIT_W;
  localparam int unsigned POLY_STEPS  = X_W / DIGIT_W;
  localparam int unsigned CNT_W       = $clog2(POLY_STEPS);

  localparam logic [K_W-1:0]     LAST_K      = K_W'(NUM_COEFF - 1);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(3721);
  localparam logic [X_W-1:0]     X_MAX       = '1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_SIX   = CFG_IDX_W'(7);

  typedef struct packed {
    logic clr;
    logic en;
  } mul_ctrl_t;

endpackage

FILE: src/ntcpl_digit_mul.sv
// Digit-serial shift-add multiplier: one multiplier digit per cycle while enabled.
// Depends on ntcpl_pkg (digit width, control struct).
module ntcpl_digit_mul import ntcpl_pkg::*; #(
  parameter int unsigned MW  = X_W,
  parameter int unsigned LW  = X_W,
  parameter bit          SGN = 1'b0
) (
  input  logic              clk_i,
  input  mul_ctrl_t         ctrl_i,
  input  logic [MW-1:0]     mcand_i,
  input  logic [DIGIT_W-1:0] digit_i,
  output logic [MW-1:0]     hi_o,
  output logic [LW-1:0]     lo_o
);

  localparam int unsigned SW = MW + DIGIT_W;

  logic [MW-1:0] hi_q, hi_d;
  logic [LW-1:0] lo_q, lo_d;
  logic [SW-1:0] mc_ext;
  logic [SW-1:0] pp;
  logic [SW-1:0] sum;
  logic          mc_sign;
  logic          hi_sign;

  always_comb begin
    mc_sign = SGN & mcand_i[MW-1];
    hi_sign = SGN & hi_q[MW-1];
    mc_ext  = {{DIGIT_W{mc_sign}}, mcand_i};
    pp      = '0;
    for (int b = 0; b < DIGIT_W; b++) begin
      if (digit_i[b]) begin
        pp = pp + (mc_ext << b);
      end
    end
    sum = {{DIGIT_W{hi_sign}}, hi_q} + pp;
    // The partial sum moves down one digit; its low digit joins the low product word.
    hi_d = sum[SW-1:DIGIT_W];
    lo_d = {sum[DIGIT_W-1:0], lo_q[LW-1:DIGIT_W]};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (ctrl_i.en) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign hi_o = hi_q;
  assign lo_o = lo_q;

endmodule

FILE: src/ntcpl_cfg_regs.sv
// Configuration registers: input scale and the seven polynomial coefficients.
// Depends on ntcpl_pkg (widths, register indexes).
module ntcpl_cfg_regs import ntcpl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [K_W-1:0]        coeff_sel_i,
  output logic [SCALE_W-1:0]    input_scale_o,
  output logic [COEFF_W-1:0]    coeff_o
);

  logic [SCALE_W-1:0] scale_q;
  logic [COEFF_W-1:0] coeff_q [NUM_COEFF];
  logic [K_W-1:0]     widx;

  assign widx = cfg_index_i[K_W-1:0] - K_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      for (int i = 0; i < NUM_COEFF; i++) begin
        coeff_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_INPUT_SCALE) begin
        scale_q <= cfg_data_i[SCALE_W-1:0];
      end else if (cfg_index_i <= REG_COEFF_SIX) begin
        coeff_q[widx] <= cfg_data_i[COEFF_W-1:0];
      end
    end
  end

  assign input_scale_o = scale_q;
  assign coeff_o = (coeff_sel_i <= LAST_K) ? coeff_q[coeff_sel_i] : '0;

endmodule

FILE: src/ntc_polynomial_linearizer_core.sv
// Top level of the NTC polynomial linearizer: sequencer, accumulator, output register.
// Depends on ntcpl_pkg, ntcpl_cfg_regs and ntcpl_digit_mul.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    sample_i
//   out      output     out_valid_o / out_ready_i  channel_o, temp_scaled_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A new sample is accepted only while the block is idle, after the previous result is registered.
// Each sample passes through the 2-bit digit multipliers: six digits for the scaled sample,
// then twelve digits plus an accumulate step for each of the six powers of x.
// Reset is asynchronous, active low, and leaves channel A next.
// A result waiting on out_ready_i holds the block in its last step; inputs wait.
module ntc_polynomial_linearizer_core import ntcpl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  channel_o,
  output logic [RES_W-1:0]      temp_scaled_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_SCALE_MUL  = 3'd1;
  localparam logic [2:0] ST_SCALE_DONE = 3'd2;
  localparam logic [2:0] ST_POLY_MUL   = 3'd3;
  localparam logic [2:0] ST_POLY_ACC   = 3'd4;
  localparam logic [2:0] ST_FINAL      = 3'd5;

  localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(SCALE_STEPS - 1);
  localparam logic [CNT_W-1:0] POLY_LAST  = CNT_W'(POLY_STEPS - 1);
  localparam logic [ACC_W-1:0] TRUNC_ADJ  = (ACC_W'(1) << OUT_SHIFT) - ACC_W'(1);
  localparam logic [RES_W-1:0] RES_MAX    = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN    = {1'b1, {(RES_W-1){1'b0}}};
  localparam int unsigned      TOP_LO     = OUT_SHIFT + RES_W - 1;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [K_W-1:0]      k_q, k_d;
  logic                phase_q, phase_d;
  logic                out_valid_q, out_valid_d;
  logic                channel_q, channel_d;
  logic [RES_W-1:0]    res_q, res_d;
  logic [X_W-1:0]      m_q, m_d;
  logic [X_W-1:0]      x_q, x_d;
  logic [ACC_W-1:0]    sum_q, sum_d;

  logic [SCALE_W-1:0]  input_scale;
  logic [COEFF_W-1:0]  coeff;
  mul_ctrl_t           mul_ctrl;
  logic [X_W-1:0]      p_mcand;
  logic [X_W-1:0]      p_hi, p_lo;
  logic [COEFF_W-1:0]  t_hi;
  logic [X_W-1:0]      t_lo;
  logic [X_W-1:0]      x_scaled;
  logic [ACC_W-1:0]    term_ext;
  logic [ACC_W-1:0]    c0_ext;
  logic [ACC_W-1:0]    adj;
  logic [ACC_W-TOP_LO-1:0] adj_top;
  logic [RES_W-1:0]    res_sat;
  logic                in_acc;
  logic                out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  ntcpl_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .coeff_sel_i  (k_q),
    .input_scale_o(input_scale),
    .coeff_o      (coeff)
  );

  always_comb begin
    mul_ctrl.clr = (state_q == ST_IDLE) || (state_q == ST_SCALE_DONE) ||
                   (state_q == ST_POLY_ACC);
    mul_ctrl.en  = (state_q == ST_SCALE_MUL) || (state_q == ST_POLY_MUL);
  end

  // The sample is multiplied by the scale first; after that the unit forms x^(k+1).
  assign p_mcand = (state_q == ST_SCALE_MUL) ? input_scale : x_q;

  ntcpl_digit_mul #(
    .MW (X_W),
    .LW (X_W),
    .SGN(1'b0)
  ) u_pow_mul (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .mcand_i(p_mcand),
    .digit_i(m_q[DIGIT_W-1:0]),
    .hi_o   (p_hi),
    .lo_o   (p_lo)
  );

  ntcpl_digit_mul #(
    .MW (COEFF_W),
    .LW (X_W),
    .SGN(1'b1)
  ) u_term_mul (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .mcand_i(coeff),
    .digit_i(m_q[DIGIT_W-1:0]),
    .hi_o   (t_hi),
    .lo_o   (t_lo)
  );

  always_comb begin
    // After six digits the product of sample and scale sits in hi and the top half of lo.
    if (p_hi[X_W-1:SAMPLE_W] != '0) begin
      x_scaled = X_MAX;
    end else begin
      x_scaled = {p_hi[SAMPLE_W-1:0], p_lo[X_W-1:X_W-SAMPLE_W]};
    end
    term_ext = {{(ACC_W-TERM_W){t_hi[COEFF_W-1]}}, t_hi, t_lo};
    c0_ext   = {{(ACC_W-COEFF_W-X_W){coeff[COEFF_W-1]}}, coeff, {X_W{1'b0}}};
    // Adding 2^30 - 1 to a negative sum makes the arithmetic shift round toward zero.
    adj      = sum_q + (sum_q[ACC_W-1] ? TRUNC_ADJ : '0);
    adj_top  = adj[ACC_W-1:TOP_LO];
    if ((&adj_top) || !(|adj_top)) begin
      res_sat = adj[TOP_LO:OUT_SHIFT];
    end else begin
      res_sat = adj[ACC_W-1] ? RES_MIN : RES_MAX;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    channel_d   = channel_q;
    res_d       = res_q;
    m_d         = m_q;
    x_d         = x_q;
    sum_d       = sum_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          m_d     = {{(X_W-SAMPLE_W){1'b0}}, sample_i};
          sum_d   = c0_ext;
          cnt_d   = '0;
          state_d = ST_SCALE_MUL;
        end
      end
      ST_SCALE_MUL: begin
        m_d = m_q >> DIGIT_W;
        if (cnt_q == SCALE_LAST) begin
          cnt_d   = '0;
          state_d = ST_SCALE_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SCALE_DONE: begin
        x_d     = x_scaled;
        m_d     = x_scaled;
        k_d     = K_W'(1);
        state_d = ST_POLY_MUL;
      end
      ST_POLY_MUL: begin
        m_d = m_q >> DIGIT_W;
        if (cnt_q == POLY_LAST) begin
          cnt_d   = '0;
          state_d = ST_POLY_ACC;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_POLY_ACC: begin
        // Odd powers are subtracted, even powers added.
        sum_d = k_q[0] ? (sum_q - term_ext) : (sum_q + term_ext);
        m_d   = p_hi;
        if (k_q == LAST_K) begin
          state_d = ST_FINAL;
        end else begin
          k_d     = k_q + K_W'(1);
          state_d = ST_POLY_MUL;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          channel_d   = phase_q;
          res_d       = res_sat;
          phase_d     = !phase_q;
          k_d         = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    channel_q <= channel_d;
    res_q     <= res_d;
    m_q       <= m_d;
    x_q       <= x_d;
    sum_q     <= sum_d;
  end

  assign out_valid_o   = out_valid_q;
  assign channel_o     = channel_q;
  assign temp_scaled_o = res_q;

  a_pw_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCALE_DONE) |=> (m_q == x_q))
    else $error("first power of x not loaded into the digit register");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SCALE_MUL))
    else $error("accepted sample did not start the scale multiply");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POLY_MUL) |-> (k_q >= K_W'(1) && k_q <= LAST_K))
    else $error("power index out of range during multiply");

  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && state_q != ST_FINAL) |=> !out_valid_o)
    else $error("result repeated after its transaction");

endmodule
